@@ hdl/qwrm_pkg.sv @@
// Shared types and constants for the queue wait / rate monitor.
// Used by qwrm_div and queue_wait_rate_monitor; depends on nothing.
package qwrm_pkg;

    localparam int DEF_FIFO_DEPTH = 256;
    localparam int DEF_TIME_BITS  = 32;

    // Q1.16 unity and divider length (17-bit dividend 65536)
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam int          DIV_STEPS = 17;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    // event kinds
    localparam logic [1:0] KIND_ARRIVAL = 2'd0;
    localparam logic [1:0] KIND_SERVICE = 2'd1;
    localparam logic [1:0] KIND_IDLE    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ARRIVAL_GAIN  = 3'd0;
    localparam logic [2:0] REG_SERVICE_GAIN  = 3'd1;
    localparam logic [2:0] REG_STARVE_LIMIT  = 3'd2;
    localparam logic [2:0] REG_INIT_ARR_RATE = 3'd3;
    localparam logic [2:0] REG_INIT_SRV_RATE = 3'd4;

    // configuration reset values
    localparam logic [16:0] RST_ARRIVAL_GAIN  = 17'd6554;
    localparam logic [16:0] RST_SERVICE_GAIN  = 17'd6554;
    localparam logic [31:0] RST_STARVE_LIMIT  = 32'd100;
    localparam logic [16:0] RST_INIT_ARR_RATE = 17'd32768;
    localparam logic [16:0] RST_INIT_SRV_RATE = 17'd65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_MUL,
        ST_COMMIT
    } qwrm_state_t;

    function automatic logic [16:0] clamp_q16(input logic [16:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

@@ hdl/qwrm_div.sv @@
// Bit-serial restoring divider: 65536 / divisor, one quotient bit per cycle.
// Depends on qwrm_pkg.
module qwrm_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [16:0] quotient
);

    logic [4:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [16:0] rem_reg;
    logic [16:0] quo_reg;
    logic [16:0] dvs_reg;

    logic [17:0] trial;
    logic        fits;

    assign trial = {rem_reg, quo_reg[16]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && !start && (cnt_reg == 5'd1);
            if (start)
            begin
                cnt_reg <= 5'(qwrm_pkg::DIV_STEPS);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                    run_reg <= 1'b0;
            end
        end
    end

    // dividend bits shift out of quo_reg as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= qwrm_pkg::ONE_Q16;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? 17'(trial - {1'b0, dvs_reg}) : trial[16:0];
            quo_reg <= {quo_reg[15:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/queue_wait_rate_monitor.sv @@
// Queue wait / rate monitor top level: stamp FIFO memory, sequencer, EWMA update.
// Depends on qwrm_pkg and qwrm_div.
//
// channel   signals                          transaction
// event     start, busy, req_type, event_time start & !busy
// result    done, wait_ticks .. wait_total   done (one cycle, no stall)
// config    cfg_valid, cfg_ready, cfg_index,  cfg_valid & cfg_ready
//           cfg_data
//
// Arrival with a rate update and a gap of at most 65536 runs the 17-step serial
// divider that forms 65536/gap, takes the quotient, then passes through the multiply
// and commit states. A longer gap skips the divider and goes straight to multiply.
// Service: stamp memory read, multiply, commit. Idle tick, drop, empty service and
// arrival without update go straight to commit.
// done pulses the cycle after commit; busy falls in that same cycle.
// Reset is asynchronous; the stamp memory is not cleared.
module queue_wait_rate_monitor
#(
    parameter int FIFO_DEPTH = qwrm_pkg::DEF_FIFO_DEPTH,
    parameter int TIME_BITS  = qwrm_pkg::DEF_TIME_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [31:0] event_time,
    output logic        done,
    output logic [31:0] wait_ticks,
    output logic        served,
    output logic        dropped,
    output logic [8:0]  jobs_waiting,
    output logic [16:0] arrival_rate_est,
    output logic [16:0] service_rate_est,
    output logic [31:0] starvation_count,
    output logic [31:0] longest_starvation,
    output logic [31:0] jobs_completed,
    output logic [31:0] jobs_arrived,
    output logic [47:0] wait_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int STAMP_W = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);

    // configuration
    logic [16:0] arrival_gain_reg;
    logic [16:0] service_gain_reg;
    logic [31:0] starve_limit_reg;

    // sequencer
    qwrm_pkg::qwrm_state_t state_reg, state_next;
    logic [1:0]         kind_reg;
    logic               ok_reg;      // arrival not full / service not empty
    logic               upd_reg;     // arrival updates the rate estimate
    logic [STAMP_W-1:0] now_reg;
    logic [STAMP_W-1:0] wait_reg;
    logic [16:0]        obs_reg;
    logic signed [35:0] prod_reg;

    // queue state
    logic [STAMP_W-1:0] stamp_mem [FIFO_DEPTH];
    logic [STAMP_W-1:0] stamp_q;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   tail_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               seen_reg;
    logic [STAMP_W-1:0] prev_reg;

    // estimates and statistics
    logic [16:0] arr_ewma_reg;
    logic [16:0] srv_ewma_reg;
    logic [31:0] idle_run_reg;
    logic [31:0] idle_max_reg;
    logic [31:0] starve_reg;
    logic [31:0] arrived_reg;
    logic [31:0] completed_reg;
    logic [47:0] wait_sum_reg;

    // result
    logic        done_reg;
    logic [31:0] wait_out_reg;
    logic        served_reg;
    logic        dropped_reg;

    logic               accept;
    logic [STAMP_W-1:0] now_in;
    logic               full;
    logic               empty;
    logic               want_upd;
    logic [STAMP_W-1:0] gap;
    logic [STAMP_W+16:0] gap_x;
    logic               gap_big;
    logic               div_start;
    logic               div_done;
    logic [16:0]        div_quo;

    logic [16:0]        g_eff;
    logic [16:0]        est_sel;
    logic [16:0]        obs_sel;
    logic signed [17:0] diff;
    logic signed [36:0] acc;
    logic signed [21:0] est_sum;
    logic [16:0]        est_new;
    logic [STAMP_W-1:0] wait_calc;
    logic [48:0]        wait_sum_x;
    logic [31:0]        run_new;
    logic               run_grows;
    logic               commit;
    logic               commit_arr;
    logic               commit_srv;

    assign accept = start && (state_reg == qwrm_pkg::ST_IDLE);
    assign busy   = (state_reg != qwrm_pkg::ST_IDLE);
    assign now_in = event_time[STAMP_W-1:0];
    assign full   = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty  = (count_reg == '0);

    assign want_upd  = seen_reg && (now_in > prev_reg);
    assign gap       = now_in - prev_reg;
    assign gap_x     = (STAMP_W + 17)'(gap);
    // a gap beyond 65536 gives an observed rate of zero
    assign gap_big   = gap_x > (STAMP_W + 17)'(qwrm_pkg::ONE_Q16);
    assign div_start = accept && (req_type == qwrm_pkg::KIND_ARRIVAL) && !full
                       && want_upd && !gap_big;

    qwrm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (gap_x[16:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qwrm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type == qwrm_pkg::KIND_ARRIVAL && !full && want_upd)
                        state_next = gap_big ? qwrm_pkg::ST_MUL : qwrm_pkg::ST_DIV;
                    else if (req_type == qwrm_pkg::KIND_SERVICE && !empty)
                        state_next = qwrm_pkg::ST_READ;
                    else
                        state_next = qwrm_pkg::ST_COMMIT;
                end
            end
            qwrm_pkg::ST_READ:   state_next = qwrm_pkg::ST_MUL;
            qwrm_pkg::ST_DIV:    state_next = div_done ? qwrm_pkg::ST_MUL : qwrm_pkg::ST_DIV;
            qwrm_pkg::ST_MUL:    state_next = qwrm_pkg::ST_COMMIT;
            qwrm_pkg::ST_COMMIT: state_next = qwrm_pkg::ST_IDLE;
            default:             state_next = qwrm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= qwrm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // transaction capture and datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= req_type;
            now_reg  <= now_in;
            ok_reg   <= (req_type == qwrm_pkg::KIND_ARRIVAL) ? !full
                      : (req_type == qwrm_pkg::KIND_SERVICE) ? !empty : 1'b0;
            upd_reg  <= (req_type == qwrm_pkg::KIND_ARRIVAL) && !full && want_upd;
            obs_reg  <= '0;
        end
        if (div_done)
            obs_reg <= div_quo;
        if (state_reg == qwrm_pkg::ST_READ)
            wait_reg <= wait_calc;
        if (state_reg == qwrm_pkg::ST_MUL)
            prod_reg <= $signed({1'b0, g_eff}) * diff;
    end

    // service wait: stamp_q is valid in ST_READ (memory read at the accept edge)
    assign wait_calc = (now_reg > stamp_q) ? (now_reg - stamp_q) : '0;

    // est' = est + ((g * (obs - est) + 0.5) >> 16)
    assign g_eff   = (kind_reg == qwrm_pkg::KIND_ARRIVAL)
                     ? qwrm_pkg::clamp_q16(arrival_gain_reg)
                     : qwrm_pkg::clamp_q16(service_gain_reg);
    assign est_sel = (kind_reg == qwrm_pkg::KIND_ARRIVAL) ? arr_ewma_reg : srv_ewma_reg;
    assign obs_sel = (kind_reg == qwrm_pkg::KIND_ARRIVAL) ? obs_reg : qwrm_pkg::ONE_Q16;
    assign diff    = $signed({1'b0, obs_sel}) - $signed({1'b0, est_sel});
    assign acc     = 37'(prod_reg) + 37'sd32768;
    // arithmetic shift floors a negative correction
    assign est_sum = $signed({5'b0, est_sel}) + 22'(acc >>> 16);

    always_comb
    begin
        if (est_sum < 0)
            est_new = '0;
        else if (est_sum > $signed({5'b0, qwrm_pkg::ONE_Q16}))
            est_new = qwrm_pkg::ONE_Q16;
        else
            est_new = est_sum[16:0];
    end

    assign commit     = (state_reg == qwrm_pkg::ST_COMMIT);
    assign commit_arr = commit && ok_reg && (kind_reg == qwrm_pkg::KIND_ARRIVAL);
    assign commit_srv = commit && ok_reg && (kind_reg == qwrm_pkg::KIND_SERVICE);
    assign wait_sum_x = {1'b0, wait_sum_reg} + 49'(wait_reg);
    assign run_grows  = (idle_run_reg != qwrm_pkg::MAX32);
    assign run_new    = run_grows ? (idle_run_reg + 32'd1) : idle_run_reg;

    // stamp memory
    always_ff @(posedge clk)
    begin
        if (commit_arr)
            stamp_mem[tail_reg] <= now_reg;
        stamp_q <= stamp_mem[head_reg];
    end

    // queue state, statistics and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrival_gain_reg <= qwrm_pkg::RST_ARRIVAL_GAIN;
            service_gain_reg <= qwrm_pkg::RST_SERVICE_GAIN;
            starve_limit_reg <= qwrm_pkg::RST_STARVE_LIMIT;
            arr_ewma_reg     <= qwrm_pkg::clamp_q16(qwrm_pkg::RST_INIT_ARR_RATE);
            srv_ewma_reg     <= qwrm_pkg::clamp_q16(qwrm_pkg::RST_INIT_SRV_RATE);
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            seen_reg         <= 1'b0;
            prev_reg         <= '0;
            idle_run_reg     <= '0;
            idle_max_reg     <= '0;
            starve_reg       <= '0;
            arrived_reg      <= '0;
            completed_reg    <= '0;
            wait_sum_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    qwrm_pkg::REG_ARRIVAL_GAIN:  arrival_gain_reg <= cfg_data[16:0];
                    qwrm_pkg::REG_SERVICE_GAIN:  service_gain_reg <= cfg_data[16:0];
                    qwrm_pkg::REG_STARVE_LIMIT:  starve_limit_reg <= cfg_data;
                    qwrm_pkg::REG_INIT_ARR_RATE:
                        arr_ewma_reg <= qwrm_pkg::clamp_q16(cfg_data[16:0]);
                    qwrm_pkg::REG_INIT_SRV_RATE:
                        srv_ewma_reg <= qwrm_pkg::clamp_q16(cfg_data[16:0]);
                    default: ;
                endcase
            end

            if (commit_arr)
            begin
                if (upd_reg)
                    arr_ewma_reg <= est_new;
                seen_reg    <= 1'b1;
                prev_reg    <= now_reg;
                tail_reg    <= (tail_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                    : tail_reg + PTR_W'(1);
                count_reg   <= count_reg + CNT_W'(1);
                arrived_reg <= (arrived_reg == qwrm_pkg::MAX32)
                               ? arrived_reg : arrived_reg + 32'd1;
            end

            if (commit_srv)
            begin
                srv_ewma_reg  <= est_new;
                head_reg      <= (head_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : head_reg + PTR_W'(1);
                count_reg     <= count_reg - CNT_W'(1);
                completed_reg <= (completed_reg == qwrm_pkg::MAX32)
                                 ? completed_reg : completed_reg + 32'd1;
                wait_sum_reg  <= wait_sum_x[48] ? qwrm_pkg::MAX48 : wait_sum_x[47:0];
                idle_run_reg  <= '0;
            end

            if (commit && kind_reg == qwrm_pkg::KIND_IDLE)
            begin
                idle_run_reg <= run_new;
                // counted only on the tick where the run grows onto the limit
                if (run_grows && run_new == starve_limit_reg && !empty
                    && starve_reg != qwrm_pkg::MAX32)
                    starve_reg <= starve_reg + 32'd1;
                if (run_new > idle_max_reg)
                    idle_max_reg <= run_new;
            end
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            wait_out_reg <= '0;
            served_reg   <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= commit;
            if (commit)
            begin
                wait_out_reg <= commit_srv ? 32'(wait_reg) : '0;
                served_reg   <= commit_srv;
                dropped_reg  <= (kind_reg == qwrm_pkg::KIND_ARRIVAL) && !ok_reg;
            end
        end
    end

    assign cfg_ready          = !busy;
    assign done               = done_reg;
    assign wait_ticks         = wait_out_reg;
    assign served             = served_reg;
    assign dropped            = dropped_reg;
    assign jobs_waiting       = 9'(count_reg);
    assign arrival_rate_est   = arr_ewma_reg;
    assign service_rate_est   = srv_ewma_reg;
    assign starvation_count   = starve_reg;
    assign longest_starvation = idle_max_reg;
    assign jobs_completed     = completed_reg;
    assign jobs_arrived       = arrived_reg;
    assign wait_total         = wait_sum_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("job count beyond FIFO depth");

    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == qwrm_pkg::ST_COMMIT))
        else $error("result strobe without commit");

    a_served_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        !(served_reg && dropped_reg))
        else $error("served and dropped in one result");

    a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == qwrm_pkg::ST_DIV)
        else $error("divider finished outside divide state");

    a_empty_no_serve: assert property (@(posedge clk) disable iff (!rst_n)
        commit_srv |-> !empty)
        else $error("service pop from empty FIFO");

endmodule
